// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by vertex_transform_project.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define VTP_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("vertex transform assertion failed");

// Implication checked at every clock edge out of reset.
`define VTP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vertex transform implication failed");

`endif

// ===== rtl/core/vtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

  // Word widths.
  localparam int unsigned QW       = 32;         // Q16.16 value
  localparam int unsigned FRAC     = 16;         // fraction bits
  localparam int unsigned NUMW     = QW + FRAC;  // dividend magnitude
  localparam int unsigned PRODW    = 2 * QW;     // exact product
  localparam int unsigned SUMW     = PRODW + 2;  // sum of four products
  localparam int unsigned CFGW     = 64;
  localparam int unsigned CFG_IDXW = 4;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned DIM      = 4;
  localparam int unsigned DIV_STAGES = NUMW;     // one quotient bit a stage

  // Register indexes.
  localparam logic [CFG_IDXW-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDXW-1:0] REG_ROW3_COLS23 = 4'd7;

  // Matrix reset in Q16.16: rows 1 to 3 as in the identity; row 0 is zero but for 2^-16 in column 1.
  localparam logic [CFGW-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0001_0000_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Word that travels beside the divider lanes.
  typedef struct packed {
    logic signed [QW-1:0] tx;
    logic signed [QW-1:0] ty;
    logic signed [QW-1:0] tz;
    logic signed [QW-1:0] tw;
    logic                 wz;
    logic                 sat;
    logic [2:0]           neg;
  } side_t;

  // Magnitude of a signed Q16.16 value as an unsigned word.
  function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vtp_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vtp_mac
  import vtp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic signed [QW-1:0]   vtx [DIM],
  input  wire logic [CFGW-1:0]        mtx [NUM_REGS],
  output logic                        sum_valid,
  output logic signed [QW-1:0]        tv [DIM],
  output logic [DIM-1:0]              row_sat
);

  logic                    prod_valid_r;
  logic signed [PRODW-1:0] prod_r [DIM][DIM];
  logic                    sum_valid_r;
  logic signed [QW-1:0]    t_r [DIM];
  logic [DIM-1:0]          sat_r;
  logic signed [QW-1:0]    t_nxt [DIM];
  logic [DIM-1:0]          sat_nxt;

  // Stage one: sixteen exact products, one multiplier each.
  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        prod_r[r][c] <= PRODW'(
          $signed(mtx[r*2 + c/2][(c%2)*QW +: QW]) * $signed(vtx[c]));
      end
    end
  end

  // Row sums at full width, floored to Q16.16, then clamped.
  always_comb begin
    logic signed [SUMW-1:0] acc;
    logic signed [SUMW-1:0] sh;
    for (int r = 0; r < DIM; r++) begin
      acc = SUMW'(prod_r[r][0]) + SUMW'(prod_r[r][1])
          + SUMW'(prod_r[r][2]) + SUMW'(prod_r[r][3]);
      sh  = acc >>> FRAC;
      if (sh > SUMW'(Q_MAX)) begin
        t_nxt[r]   = Q_MAX;
        sat_nxt[r] = 1'b1;
      end else if (sh < SUMW'(Q_MIN)) begin
        t_nxt[r]   = Q_MIN;
        sat_nxt[r] = 1'b1;
      end else begin
        t_nxt[r]   = sh[QW-1:0];
        sat_nxt[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    sat_r <= sat_nxt;
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      prod_valid_r <= in_valid;
      sum_valid_r  <= prod_valid_r;
    end
  end

  assign sum_valid = sum_valid_r;
  assign tv        = t_r;
  assign row_sat   = sat_r;

endmodule

`default_nettype wire

// ===== rtl/core/vtp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per register stage.
module vtp_div
  import vtp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [QW-1:0]   den,
  output logic [NUMW-1:0]      quo
);

  logic [QW-1:0]   rem_r [DIV_STAGES+1];
  logic [NUMW-1:0] num_r [DIV_STAGES+1];
  logic [NUMW-1:0] quo_r [DIV_STAGES+1];
  logic [QW-1:0]   den_r [DIV_STAGES+1];

  assign rem_r[0] = '0;
  assign num_r[0] = num;
  assign quo_r[0] = '0;
  assign den_r[0] = den;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [QW:0] rem_in;
    logic [QW:0] diff;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
      rem_in = {rem_r[k], num_r[k][NUMW-1]};
      diff   = rem_in - {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= diff[QW] ? rem_in[QW-1:0] : diff[QW-1:0];
      quo_r[k+1] <= {quo_r[k][NUMW-2:0], ~diff[QW]};
      num_r[k+1] <= {num_r[k][NUMW-2:0], 1'b0};
      den_r[k+1] <= den_r[k];
    end
  end

  assign quo = quo_r[DIV_STAGES];

endmodule

`default_nettype wire

// ===== rtl/core/vertex_transform_project.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Vertex transform with perspective divide, signed Q16.16. A vertex is taken
// in every cycle in which start is high and busy is low; busy is high only
// during reset. Each result appears with out_valid high for exactly one
// cycle, and cannot be held off: two stages form and sum the sixteen
// products, one stage prepares the divide, three 48-stage restoring dividers
// produce one quotient bit a stage, and a final stage restores the sign and
// clamps. The user must write matrix words through the cfg_ channel (always
// ready) only while no vertex is in flight; the block does not enforce this.
module vertex_transform_project
  import vtp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [QW-1:0] in_x,
  input  wire logic signed [QW-1:0] in_y,
  input  wire logic signed [QW-1:0] in_z,
  input  wire logic signed [QW-1:0] in_w,
  output logic                      out_valid,
  output logic signed [QW-1:0]      out_x,
  output logic signed [QW-1:0]      out_y,
  output logic signed [QW-1:0]      out_z,
  output logic signed [QW-1:0]      out_w,
  output logic                      out_w_was_zero,
  output logic                      out_saturated,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDXW-1:0]  cfg_index,
  input  wire logic [CFGW-1:0]      cfg_data
);

  logic [CFGW-1:0]      cfg_r [NUM_REGS];
  logic                 accept;
  logic signed [QW-1:0] vtx [DIM];
  logic                 sum_valid;
  logic signed [QW-1:0] tv [DIM];
  logic [DIM-1:0]       row_sat;

  logic                 prep_valid_r;
  logic [NUMW-1:0]      num_r [3];
  logic [QW-1:0]        den_r;
  logic [NUMW-1:0]      quo [3];
  side_t                side_r [DIV_STAGES+1];
  logic [DIV_STAGES-1:0] dval_r;

  logic                 out_valid_r;
  logic signed [QW-1:0] res_r [3];
  logic signed [QW-1:0] res_nxt [3];
  logic                 sat_nxt;
  side_t                fin;
  logic                 out_wz_r;
  logic                 out_sat_r;
  logic signed [QW-1:0] out_w_r;

  assign busy      = !rst_n;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Matrix registers; writes beyond the last index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_index <= REG_ROW3_COLS23) begin
      cfg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign vtx[0] = in_x;
  assign vtx[1] = in_y;
  assign vtx[2] = in_z;
  assign vtx[3] = in_w;

  vtp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .vtx       (vtx),
    .mtx       (cfg_r),
    .sum_valid (sum_valid),
    .tv        (tv),
    .row_sat   (row_sat)
  );

  // Divide preparation: magnitudes, quotient signs and the zero-w test.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_r[i] <= {mag(tv[i]), {FRAC{1'b0}}};
    end
    den_r            <= mag(tv[3]);
    side_r[0].tx     <= tv[0];
    side_r[0].ty     <= tv[1];
    side_r[0].tz     <= tv[2];
    side_r[0].tw     <= tv[3];
    side_r[0].wz     <= (tv[3] == '0);
    side_r[0].sat    <= |row_sat;
    side_r[0].neg    <= {tv[2][QW-1] ^ tv[3][QW-1], tv[1][QW-1] ^ tv[3][QW-1],
                         tv[0][QW-1] ^ tv[3][QW-1]};
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    vtp_div u_div (
      .clk (clk),
      .num (num_r[l]),
      .den (den_r),
      .quo (quo[l])
    );
  end

  // Side word travels alongside the divider stages.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      side_r[k+1] <= side_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
      dval_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      prep_valid_r <= sum_valid;
      dval_r       <= {dval_r[DIV_STAGES-2:0], prep_valid_r};
      out_valid_r  <= dval_r[DIV_STAGES-1];
    end
  end

  // Final stage: sign restore and clamp, or pass-through when w is zero.
  assign fin = side_r[DIV_STAGES];

  always_comb begin
    logic signed [QW-1:0] pass [3];
    pass[0] = fin.tx;
    pass[1] = fin.ty;
    pass[2] = fin.tz;
    sat_nxt = fin.sat;
    for (int i = 0; i < 3; i++) begin
      if (fin.wz) begin
        res_nxt[i] = pass[i];
      end else if (fin.neg[i]) begin
        if (quo[i] > NUMW'(unsigned'(Q_MIN))) begin
          res_nxt[i] = Q_MIN;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[i] = -$signed(quo[i][QW-1:0]);
        end
      end else begin
        if (quo[i] > NUMW'(unsigned'(Q_MAX))) begin
          res_nxt[i] = Q_MAX;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[i] = $signed(quo[i][QW-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_w_r   <= fin.tw;
    out_wz_r  <= fin.wz;
    out_sat_r <= sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_x          = res_r[0];
  assign out_y          = res_r[1];
  assign out_z          = res_r[2];
  assign out_w          = out_w_r;
  assign out_w_was_zero = out_wz_r;
  assign out_saturated  = out_sat_r;

  // A zero-w flag must come with a zero transformed w.
  `VTP_ASSERT_IMP(a_wz_w, clk, rst_n, out_valid && out_w_was_zero, out_w == '0)
  // The divisor is never zero for a word that is really divided.
  `VTP_ASSERT_IMP(a_den_nz, clk, rst_n, prep_valid_r && !side_r[0].wz, den_r != '0)
  // The divide stage entry is sum_valid registered, in the cycle after it.
  `VTP_ASSERT(a_prep_seq, clk, rst_n, prep_valid_r == ($past(sum_valid) && $past(rst_n)))

endmodule

`default_nettype wire
